/* rtl/ucd_pkg.sv */
// Shared types, field widths and small arithmetic helpers for the Unix time / civil date converter.
// No dependencies; used by every RTL file of the block.
package ucd_pkg;

    localparam int EPOCH_W  = 32;
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // register stages in each conversion path
    localparam int PIPE_DEPTH = 8;

    // operation codes
    localparam logic OP_TO_SECS = 1'b0;
    localparam logic OP_TO_DATE = 1'b1;

    // last month that belongs to the previous March-based year
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [SECOND_W-1:0] second;
    } civil_t;

    // first day of a March-based month within its year: (153*mm + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mm);
        logic [8:0] r;
        case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            4'd13:   r = 9'd398;
            4'd14:   r = 9'd428;
            default: r = 9'd459;
        endcase
        return r;
    endfunction

    // x / 25 for 8-bit x, by reciprocal 41/1024
    function automatic logic [3:0] div25(input logic [7:0] x);
        logic [15:0] p;
        p = {8'd0, x} * 16'd41;
        return p[13:10];
    endfunction

endpackage

/* rtl/ucd_to_secs.sv */
// Date and time to seconds since 1970, days-from-civil method, PIPE_DEPTH register stages.
// Depends on ucd_pkg.
module ucd_to_secs (
    input  logic                          clk,
    input  ucd_pkg::civil_t               civil,
    output logic [ucd_pkg::EPOCH_W-1:0]   epoch_seconds
);

    localparam int PAD = ucd_pkg::PIPE_DEPTH - 5;

    // stage 1: era, year of era, day of year, time of day
    logic signed [12:0] y_adj;
    logic               before_mar;
    logic [3:0]         era_u;
    logic [11:0]        yoe_full;
    logic [3:0]         mm;
    logic [4:0]         s1_era_next, s1_era_reg;
    logic [8:0]         s1_yoe_next, s1_yoe_reg;
    logic [9:0]         s1_doy_next, s1_doy_reg;
    logic [16:0]        s1_tod_next, s1_tod_reg;
    // stage 2: day of era, era offset in days
    logic [18:0]        s2_doe_next, s2_doe_reg;
    logic [20:0]        s2_eday_next, s2_eday_reg;
    logic [16:0]        s2_tod_reg;
    // stage 3: day count
    logic [21:0]        s3_days_next, s3_days_reg;
    logic [16:0]        s3_tod_reg;
    // stage 4: day count in seconds
    logic [31:0]        s4_prod_next, s4_prod_reg;
    logic [16:0]        s4_tod_reg;
    // stage 5: add time of day
    logic [31:0]        s5_secs_next, s5_secs_reg;
    logic [31:0]        pad_reg [PAD];

    always_comb
    begin
        before_mar = (civil.month <= ucd_pkg::MONTH_FEB);
        y_adj      = $signed({1'b0, civil.year}) - $signed({12'd0, before_mar});
        era_u      = ucd_pkg::div25(y_adj[11:4]);
        yoe_full   = y_adj[11:0] - 12'(era_u * 12'd400);
        // only year -1 is negative: era -1, year 399 of that era
        if (y_adj[12])
        begin
            s1_era_next = 5'h1F;
            s1_yoe_next = 9'd399;
        end
        else
        begin
            s1_era_next = {1'b0, era_u};
            s1_yoe_next = yoe_full[8:0];
        end
        mm          = (civil.month > ucd_pkg::MONTH_FEB) ? civil.month - 4'd3
                                                           : civil.month + 4'd9;
        s1_doy_next = 10'({1'b0, ucd_pkg::month_start(mm)}) + 10'({5'd0, civil.day}) - 10'd1;
        s1_tod_next = 17'(civil.hour * 17'd3600) + 17'(civil.minute * 17'd60)
                    + 17'(civil.second);

        s2_doe_next  = 19'(s1_yoe_reg * 19'd365) + 19'(s1_yoe_reg[8:2])
                     - 19'(ucd_pkg::div25({1'b0, s1_yoe_reg[8:2]}))
                     + {{9{s1_doy_reg[9]}}, s1_doy_reg};
        s2_eday_next = 21'({{16{s1_era_reg[4]}}, s1_era_reg} * 21'd146097) - 21'd719468;

        s3_days_next = {{3{s2_doe_reg[18]}}, s2_doe_reg} + {s2_eday_reg[20], s2_eday_reg};

        // wraps modulo 2^32, also for negative day counts
        s4_prod_next = 32'({{10{s3_days_reg[21]}}, s3_days_reg} * 32'd86400);

        s5_secs_next = s4_prod_reg + {15'd0, s4_tod_reg};
    end

    always_ff @(posedge clk)
    begin
        s1_era_reg  <= s1_era_next;
        s1_yoe_reg  <= s1_yoe_next;
        s1_doy_reg  <= s1_doy_next;
        s1_tod_reg  <= s1_tod_next;
        s2_doe_reg  <= s2_doe_next;
        s2_eday_reg <= s2_eday_next;
        s2_tod_reg  <= s1_tod_reg;
        s3_days_reg <= s3_days_next;
        s3_tod_reg  <= s2_tod_reg;
        s4_prod_reg <= s4_prod_next;
        s4_tod_reg  <= s3_tod_reg;
        s5_secs_reg <= s5_secs_next;
        pad_reg[0]  <= s5_secs_reg;
        for (int i = 1; i < PAD; i++)
        begin
            pad_reg[i] <= pad_reg[i-1];
        end
    end

    // delay line matches the longer seconds-to-date path
    assign epoch_seconds = pad_reg[PAD-1];

endmodule

/* rtl/ucd_to_date.sv */
// Seconds since 1970 to date and time, civil-from-days method, PIPE_DEPTH register stages.
// Depends on ucd_pkg; divisions by constants use reciprocal multiplies, except the era and century terms (compares).
module ucd_to_date (
    input  logic                        clk,
    input  logic [ucd_pkg::EPOCH_W-1:0] epoch_seconds,
    output ucd_pkg::civil_t             civil
);

    // stage 1: day count = secs / 86400 = (secs >> 7) / 675
    logic [50:0] p1;
    logic [15:0] s1_q_next, s1_q_reg;
    logic [31:0] s1_secs_reg;
    // stage 2: seconds of day, day number from 0000-03-01
    logic [16:0] s2_rem_next, s2_rem_reg;
    logic [19:0] s2_z_next, s2_z_reg;
    // stage 3: era, day of era, hour
    logic [33:0] p3;
    logic [2:0]  s3_era_next, s3_era_reg;
    logic [17:0] s3_doe_next, s3_doe_reg;
    logic [4:0]  s3_hour_next, s3_hour_reg;
    logic [16:0] s3_rem_reg;
    // stage 4: leap-corrected day of era, seconds of hour
    logic [31:0] p4;
    logic [2:0]  leap_c;
    logic [17:0] s4_n_next, s4_n_reg;
    logic [11:0] s4_r2_next, s4_r2_reg;
    logic [2:0]  s4_era_reg;
    logic [17:0] s4_doe_reg;
    logic [4:0]  s4_hour_reg;
    // stage 5: year of era, minute
    logic [35:0] p5;
    logic [24:0] pm;
    logic [8:0]  s5_yoe_next, s5_yoe_reg;
    logic [5:0]  s5_min_next, s5_min_reg;
    logic [2:0]  s5_era_reg;
    logic [17:0] s5_doe_reg;
    logic [4:0]  s5_hour_reg;
    logic [11:0] s5_r2_reg;
    // stage 6: day of year, second
    logic [17:0] yr_days;
    logic [17:0] doy_full;
    logic [11:0] sec_full;
    logic [8:0]  s6_doy_next, s6_doy_reg;
    logic [5:0]  s6_sec_next, s6_sec_reg;
    logic [8:0]  s6_yoe_reg;
    logic [2:0]  s6_era_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    // stage 7: March-based month
    logic [10:0] mx;
    logic [21:0] p7;
    logic [3:0]  s7_mp_next, s7_mp_reg;
    logic [8:0]  s7_doy_reg;
    logic [8:0]  s7_yoe_reg;
    logic [2:0]  s7_era_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;
    // stage 8: civil fields
    logic [8:0]  day_full;
    logic [3:0]  mon;
    ucd_pkg::civil_t s8_next, s8_reg;

    always_comb
    begin
        p1        = 51'({25'd0, epoch_seconds[31:7]} * 51'd50903317);
        s1_q_next = p1[50:35];

        s2_rem_next = s1_secs_reg[16:0] - 17'(s1_q_reg * 17'd86400);
        s2_z_next   = {4'd0, s1_q_reg} + 20'd719468;

        // era by compare against era boundaries
        if (s2_z_reg >= 20'd730485)
            s3_era_next = 3'd5;
        else if (s2_z_reg >= 20'd584388)
            s3_era_next = 3'd4;
        else if (s2_z_reg >= 20'd438291)
            s3_era_next = 3'd3;
        else if (s2_z_reg >= 20'd292194)
            s3_era_next = 3'd2;
        else if (s2_z_reg >= 20'd146097)
            s3_era_next = 3'd1;
        else
            s3_era_next = 3'd0;
        s3_doe_next  = 18'(s2_z_reg - 20'(s3_era_next * 20'd146097));
        p3           = {17'd0, s2_rem_reg} * 34'd74566;
        s3_hour_next = p3[32:28];

        // doe - doe/1460 + doe/36524 - doe/146096
        p4     = {16'd0, s3_doe_reg[17:2]} * 32'd45965;
        leap_c = 3'(s3_doe_reg >= 18'd36524) + 3'(s3_doe_reg >= 18'd73048)
               + 3'(s3_doe_reg >= 18'd109572) + 3'(s3_doe_reg >= 18'd146096);
        s4_n_next  = s3_doe_reg - {10'd0, p4[31:24]} + {15'd0, leap_c}
                   - {17'd0, s3_doe_reg == 18'd146096};
        s4_r2_next = 12'(s3_rem_reg - 17'(s3_hour_reg * 17'd3600));

        p5          = {18'd0, s4_n_reg} * 36'd183860;
        s5_yoe_next = p5[34:26];
        pm          = {13'd0, s4_r2_reg} * 25'd4370;
        s5_min_next = pm[23:18];

        yr_days     = 18'(s5_yoe_reg * 18'd365) + 18'(s5_yoe_reg[8:2])
                    - 18'(ucd_pkg::div25({1'b0, s5_yoe_reg[8:2]}));
        doy_full    = s5_doe_reg - yr_days;
        s6_doy_next = doy_full[8:0];
        sec_full    = s5_r2_reg - 12'(s5_min_reg * 12'd60);
        s6_sec_next = sec_full[5:0];

        mx         = 11'(s6_doy_reg * 11'd5) + 11'd2;
        p7         = {11'd0, mx} * 22'd1714;
        s7_mp_next = p7[21:18];

        day_full = s7_doy_reg - ucd_pkg::month_start(s7_mp_reg) + 9'd1;
        mon      = (s7_mp_reg < 4'd10) ? s7_mp_reg + 4'd3 : s7_mp_reg - 4'd9;
        s8_next.year   = 12'(s7_yoe_reg) + 12'(s7_era_reg * 12'd400)
                       + 12'(mon <= ucd_pkg::MONTH_FEB);
        s8_next.month  = mon;
        s8_next.day    = day_full[4:0];
        s8_next.hour   = s7_hour_reg;
        s8_next.minute = s7_min_reg;
        s8_next.second = s7_sec_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_q_reg    <= s1_q_next;
        s1_secs_reg <= epoch_seconds;
        s2_rem_reg  <= s2_rem_next;
        s2_z_reg    <= s2_z_next;
        s3_era_reg  <= s3_era_next;
        s3_doe_reg  <= s3_doe_next;
        s3_hour_reg <= s3_hour_next;
        s3_rem_reg  <= s2_rem_reg;
        s4_n_reg    <= s4_n_next;
        s4_r2_reg   <= s4_r2_next;
        s4_era_reg  <= s3_era_reg;
        s4_doe_reg  <= s3_doe_reg;
        s4_hour_reg <= s3_hour_reg;
        s5_yoe_reg  <= s5_yoe_next;
        s5_min_reg  <= s5_min_next;
        s5_era_reg  <= s4_era_reg;
        s5_doe_reg  <= s4_doe_reg;
        s5_hour_reg <= s4_hour_reg;
        s5_r2_reg   <= s4_r2_reg;
        s6_doy_reg  <= s6_doy_next;
        s6_sec_reg  <= s6_sec_next;
        s6_yoe_reg  <= s5_yoe_reg;
        s6_era_reg  <= s5_era_reg;
        s6_hour_reg <= s5_hour_reg;
        s6_min_reg  <= s5_min_reg;
        s7_mp_reg   <= s7_mp_next;
        s7_doy_reg  <= s6_doy_reg;
        s7_yoe_reg  <= s6_yoe_reg;
        s7_era_reg  <= s6_era_reg;
        s7_hour_reg <= s6_hour_reg;
        s7_min_reg  <= s6_min_reg;
        s7_sec_reg  <= s6_sec_reg;
        s8_reg      <= s8_next;
    end

    assign civil = s8_reg;

endmodule

/* rtl/unix_time_civil_date_converter.sv */
// Unix time / civil date converter, top level. Depends on ucd_pkg, ucd_to_secs, ucd_to_date.
// The done strobe follows the start transfer through the 8 datapath stages and the output reg.
// Throughput: one conversion per cycle; busy is always low and the receiver cannot stall.
// The depth is set by the seconds-to-date path.
// Reset clears the valid pipeline and done; datapath registers are not reset.
module unix_time_civil_date_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] epoch_seconds_in,
    input  logic [11:0] year_in,
    input  logic [3:0]  month_in,
    input  logic [4:0]  day_in,
    input  logic [4:0]  hour_in,
    input  logic [5:0]  minute_in,
    input  logic [5:0]  second_in,
    output logic        done,
    output logic [31:0] epoch_seconds_out,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out
);

    localparam int DEPTH = ucd_pkg::PIPE_DEPTH;

    ucd_pkg::civil_t    civil_in;
    ucd_pkg::civil_t    civil_res;
    logic [31:0]        secs_res;
    logic [DEPTH-1:0]   vld_next, vld_reg;
    logic [DEPTH-1:0]   op_reg;
    logic               done_reg;
    logic [31:0]        secs_out_next, secs_out_reg;
    ucd_pkg::civil_t    civil_out_next, civil_out_reg;

    assign busy = 1'b0;

    assign civil_in.year   = year_in;
    assign civil_in.month  = month_in;
    assign civil_in.day    = day_in;
    assign civil_in.hour   = hour_in;
    assign civil_in.minute = minute_in;
    assign civil_in.second = second_in;

    // both conversions run on every transfer; opcode picks the result
    ucd_to_secs u_to_secs (
        .clk           (clk),
        .civil         (civil_in),
        .epoch_seconds (secs_res)
    );

    ucd_to_date u_to_date (
        .clk           (clk),
        .epoch_seconds (epoch_seconds_in),
        .civil         (civil_res)
    );

    // valid bits follow the data
    assign vld_next = {vld_reg[DEPTH-2:0], start && !busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= {op_reg[DEPTH-2:0], opcode};
    end

    // output select; fields the operation does not produce read zero
    always_comb
    begin
        if (op_reg[DEPTH-1] == ucd_pkg::OP_TO_DATE)
        begin
            secs_out_next  = '0;
            civil_out_next = civil_res;
        end
        else
        begin
            secs_out_next  = secs_res;
            civil_out_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        secs_out_reg  <= secs_out_next;
        civil_out_reg <= civil_out_next;
    end

    assign done              = done_reg;
    assign epoch_seconds_out = secs_out_reg;
    assign year_out          = civil_out_reg.year;
    assign month_out         = civil_out_reg.month;
    assign day_out           = civil_out_reg.day;
    assign hour_out          = civil_out_reg.hour;
    assign minute_out        = civil_out_reg.minute;
    assign second_out        = civil_out_reg.second;

    // a result only appears for a matching start transfer, carried through the valid pipeline and done register
    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, DEPTH + 1))
        else $error("done without a matching start transfer");

    // a result carries either seconds or a date, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (epoch_seconds_out == 32'd0 || (year_out == 12'd0 && month_out == 4'd0
                  && day_out == 5'd0)))
        else $error("result mixes seconds and date fields");

    // a date result has month 1 to 12, day at least 1, a legal time of day and a year from 1970
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && month_out != 4'd0) |-> (month_out <= 4'd12 && day_out >= 5'd1
            && hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59
            && year_out >= 12'd1970))
        else $error("date result out of range");

endmodule
